[rtl/core/rpi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpi_pkg: shared types and constants of the RGBA palette indexer
// Palette size, field widths, cell chain types and the 8-to-4 bit rounding.
// ----------------------------------------------------------------------------
package rpi_pkg;

	localparam int MAX_COLORS = 15;
	localparam int CNT_W      = 4;
	localparam int IDX_W      = 4;
	localparam int CHAN_W     = 8;
	localparam int QCH_W      = 4;
	localparam int COLOR_W    = 12;

	localparam logic [CHAN_W-1:0] ALPHA_RESET = 8'd128;

	typedef struct packed {
		logic             valid;
		logic             opaque;
		logic             first;
		logic [COLOR_W-1:0] color;
	} pix_s1_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             append;
	} cell_ctl_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] index;
	} hit_chain_t;

	// (c*15+127)/255 equals (c+8)/17; divide by 17 as multiply by 241 then >>12
	function automatic logic [QCH_W-1:0] quant4(input logic [CHAN_W-1:0] c);
		logic [15:0] p;
		p = 16'({1'b0, c} + 9'd8) * 16'd241;
		return p[15:12];
	endfunction

endpackage
`default_nettype wire

[rtl/core/rpi_pix_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpi_pix_if: pixel input channel
// Valid/ready channel carrying one RGBA pixel and the first-pixel mark.
// ----------------------------------------------------------------------------
interface rpi_pix_if;
	logic                      valid;
	logic                      ready;
	logic [rpi_pkg::CHAN_W-1:0] red;
	logic [rpi_pkg::CHAN_W-1:0] green;
	logic [rpi_pkg::CHAN_W-1:0] blue;
	logic [rpi_pkg::CHAN_W-1:0] alpha;
	logic                      first_pixel;

	modport source (output valid, red, green, blue, alpha, first_pixel, input ready);
	modport sink   (input valid, red, green, blue, alpha, first_pixel, output ready);
endinterface
`default_nettype wire

[rtl/core/rpi_res_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpi_res_if: result output channel
// Valid/ready channel carrying the palette index, new-entry mark, color, overflow.
// ----------------------------------------------------------------------------
interface rpi_res_if;
	logic                       valid;
	logic                       ready;
	logic [rpi_pkg::IDX_W-1:0]   color_index;
	logic                       new_entry;
	logic [rpi_pkg::COLOR_W-1:0] entry_color;
	logic                       overflow;

	modport source (output valid, color_index, new_entry, entry_color, overflow, input ready);
	modport sink   (input valid, color_index, new_entry, entry_color, overflow, output ready);
endinterface
`default_nettype wire

[rtl/core/rpi_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpi_cfg_if: configuration write channel
// Valid/ready channel carrying the alpha threshold write data.
// ----------------------------------------------------------------------------
interface rpi_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [rpi_pkg::CHAN_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/core/rpi_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpi_front: threshold register and quantizing input stage
// Hold the alpha threshold; round channels to 4 bits and register the pixel.
// ----------------------------------------------------------------------------
module rpi_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [rpi_pkg::CHAN_W-1:0]  cfg_data,
	input  wire logic                        load,
	input  wire logic                        advance,
	input  wire logic [rpi_pkg::CHAN_W-1:0]  red,
	input  wire logic [rpi_pkg::CHAN_W-1:0]  green,
	input  wire logic [rpi_pkg::CHAN_W-1:0]  blue,
	input  wire logic [rpi_pkg::CHAN_W-1:0]  alpha,
	input  wire logic                        first_pixel,
	output rpi_pkg::pix_s1_t                 pix_s1
);
	import rpi_pkg::*;

	logic [CHAN_W-1:0]  threshold_q;
	logic               valid_s1;
	logic               opaque_s1;
	logic               first_s1;
	logic [COLOR_W-1:0] color_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= ALPHA_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			opaque_s1 <= (alpha >= threshold_q);
			first_s1  <= first_pixel;
			color_s1  <= {quant4(red), quant4(green), quant4(blue)};
		end
	end

	assign pix_s1 = '{valid: valid_s1, opaque: opaque_s1, first: first_s1, color: color_s1};

endmodule
`default_nettype wire

[rtl/core/rpi_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpi_cell: one palette entry of the lookup chain
// Hold one learned color, compare it, and pass the first hit down the chain.
// ----------------------------------------------------------------------------
module rpi_cell (
	input  wire logic                        clk,
	input  wire logic [rpi_pkg::CNT_W-1:0]   pos,
	input  wire logic [rpi_pkg::COLOR_W-1:0] color,
	input  wire rpi_pkg::cell_ctl_t          ctl,
	input  wire rpi_pkg::hit_chain_t         chain_in,
	output rpi_pkg::hit_chain_t              chain_out
);
	import rpi_pkg::*;

	logic [COLOR_W-1:0] entry_q;
	logic               in_use;
	logic               hit;

	assign in_use = (pos < ctl.count);
	assign hit    = in_use && (entry_q == color);

	always_comb begin
		chain_out.found = chain_in.found | hit;
		if (chain_in.found) begin
			chain_out.index = chain_in.index;
		end else if (hit) begin
			chain_out.index = IDX_W'(pos + 1'b1);
		end else begin
			chain_out.index = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.append && (pos == ctl.count)) begin
			entry_q <= color;
		end
	end

endmodule
`default_nettype wire

[rtl/core/rgba_palette_indexer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_palette_indexer: RGBA pixel to 4-bit palette index
// Quantize each opaque pixel to 12-bit color and look it up in a learned
// palette held in a chain of compare cells; append unseen colors.
//
// Channel  Dir  Payload
// pix      in   red, green, blue, alpha, first_pixel
// cfg      in   data (alpha threshold)
// res      out  color_index, new_entry, entry_color, overflow
//
// One pixel per cycle unless res stalls; s1 registers pixels, s2 the results.
// The lookup and palette append happen in the same stage through the cell
// chain, so each pixel sees every earlier pixel's update.
// Reset clears the fill count, overflow flag, threshold (128) and valids.
// A stalled result holds both stages; cfg is always ready.
// ----------------------------------------------------------------------------
module rgba_palette_indexer (
	input wire logic clk,
	input wire logic arst_n,
	rpi_pix_if.sink   pix,
	rpi_cfg_if.sink   cfg,
	rpi_res_if.source res
);
	import rpi_pkg::*;

	pix_s1_t            pix_s1;
	logic               advance;
	logic               load;
	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;
	logic [CNT_W-1:0]   cnt_eff;
	logic               ovf_eff;
	logic               active;
	logic               has_room;
	logic               append;
	logic [CNT_W-1:0]   count_nxt;
	logic               ovf_nxt;
	logic [IDX_W-1:0]   index_nxt;
	cell_ctl_t          cell_ctl;
	hit_chain_t         chain [MAX_COLORS+1];

	logic               valid_s2;
	logic [IDX_W-1:0]   index_s2;
	logic               new_s2;
	logic [COLOR_W-1:0] color_s2;
	logic               ovf_s2;

	assign advance   = !valid_s2 || res.ready;
	assign pix.ready = !pix_s1.valid || advance;
	assign load      = pix.valid && pix.ready;
	assign cfg.ready = 1'b1;

	rpi_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg.valid),
		.cfg_data    (cfg.data),
		.load        (load),
		.advance     (advance),
		.red         (pix.red),
		.green       (pix.green),
		.blue        (pix.blue),
		.alpha       (pix.alpha),
		.first_pixel (pix.first_pixel),
		.pix_s1      (pix_s1)
	);

	assign cnt_eff  = pix_s1.first ? '0 : count_q;
	assign ovf_eff  = pix_s1.first ? 1'b0 : ovf_q;
	assign active   = pix_s1.opaque && !ovf_eff;
	assign has_room = (cnt_eff < CNT_W'(MAX_COLORS));
	assign append   = advance && pix_s1.valid && active && !chain[MAX_COLORS].found && has_room;

	assign cell_ctl = '{count: cnt_eff, append: append};
	assign chain[0] = '0;

	for (genvar g = 0; g < MAX_COLORS; g++) begin : g_cell
		rpi_cell u_cell (
			.clk       (clk),
			.pos       (CNT_W'(g)),
			.color     (pix_s1.color),
			.ctl       (cell_ctl),
			.chain_in  (chain[g]),
			.chain_out (chain[g+1])
		);
	end

	always_comb begin
		count_nxt = cnt_eff;
		ovf_nxt   = ovf_eff;
		index_nxt = '0;
		if (active) begin
			if (chain[MAX_COLORS].found) begin
				index_nxt = chain[MAX_COLORS].index;
			end else if (has_room) begin
				count_nxt = CNT_W'(cnt_eff + 1'b1);
				index_nxt = IDX_W'(cnt_eff + 1'b1);
			end else begin
				ovf_nxt = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= pix_s1.valid;
			if (pix_s1.valid) begin
				count_q <= count_nxt;
				ovf_q   <= ovf_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pix_s1.valid) begin
			index_s2 <= index_nxt;
			new_s2   <= append;
			color_s2 <= pix_s1.opaque ? pix_s1.color : '0;
			ovf_s2   <= ovf_nxt;
		end
	end

	assign res.valid       = valid_s2;
	assign res.color_index = index_s2;
	assign res.new_entry   = new_s2;
	assign res.entry_color = color_s2;
	assign res.overflow    = ovf_s2;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_COLORS))
		else $error("palette fill count beyond capacity");

	a_new_entry_index: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.new_entry) |-> (res.color_index != '0 && !res.overflow))
		else $error("new entry without index or with overflow");

	a_overflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && pix_s1.valid && ovf_q && !pix_s1.first) |=>
		(res.color_index == '0 && !res.new_entry && res.overflow))
		else $error("pixel after overflow not mapped to index zero");
`endif

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for rgba_palette_indexer
// Drives pixels over the valid/ready channels with random gaps and stalls.
// A scoreboard mirrors the palette learning for every accepted transaction
// and compares each result, field by field, in order. Phases run under
// several alpha thresholds: directed corner pixels first, then random images
// built from small color sets, mixed with random noise pixels.
// ----------------------------------------------------------------------------
module tb_top;
	import rpi_pkg::*;

	typedef struct {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
		logic              first;
	} pixel_t;

	typedef struct {
		logic [IDX_W-1:0]   index;
		logic               fresh;
		logic [COLOR_W-1:0] color;
		logic               overflow;
	} lookup_t;

	class palette_scoreboard;
		logic [COLOR_W-1:0] learned [MAX_COLORS];
		int                 used;
		logic               overflowed;
		logic [CHAN_W-1:0]  threshold;
		lookup_t            expected_lookups [$];
		int                 errors;

		function new();
			used = 0;
			overflowed = 1'b0;
			threshold = ALPHA_RESET;
			errors = 0;
		endfunction

		function logic [QCH_W-1:0] round_to_nibble(logic [CHAN_W-1:0] c);
			int unsigned v;
			v = c;
			return QCH_W'((v * 15 + 127) / 255);
		endfunction

		function void set_threshold(logic [CHAN_W-1:0] value);
			threshold = value;
		endfunction

		function int pending();
			return expected_lookups.size();
		endfunction

		function void note_pixel(pixel_t p);
			lookup_t e;
			int      hit;
			e.index = '0;
			e.fresh = 1'b0;
			e.color = '0;
			hit = -1;
			if (p.first) begin
				used = 0;
				overflowed = 1'b0;
			end
			if (p.alpha >= threshold) begin
				e.color = {round_to_nibble(p.red), round_to_nibble(p.green),
					round_to_nibble(p.blue)};
				if (!overflowed) begin
					for (int i = 0; i < used; i++)
						if (hit < 0 && learned[i] == e.color)
							hit = i;
					if (hit >= 0) begin
						e.index = IDX_W'(hit + 1);
					end else if (used < MAX_COLORS) begin
						learned[used] = e.color;
						used++;
						e.index = IDX_W'(used);
						e.fresh = 1'b1;
					end else begin
						overflowed = 1'b1;
					end
				end
			end
			e.overflow = overflowed;
			expected_lookups = {expected_lookups, e};
		endfunction

		function void check_result(logic [IDX_W-1:0] index, logic fresh,
			logic [COLOR_W-1:0] color, logic overflow);
			lookup_t e;
			if (expected_lookups.size() == 0) begin
				$display("%0t: unexpected result index %0d new %0b color %03h ovf %0b",
					$time, index, fresh, color, overflow);
				errors++;
				return;
			end
			e = expected_lookups.pop_front();
			if (index !== e.index) begin
				$display("%0t: color_index expected %0d got %0d", $time, e.index, index);
				errors++;
			end
			if (fresh !== e.fresh) begin
				$display("%0t: new_entry expected %0b got %0b", $time, e.fresh, fresh);
				errors++;
			end
			if (color !== e.color) begin
				$display("%0t: entry_color expected %03h got %03h", $time, e.color, color);
				errors++;
			end
			if (overflow !== e.overflow) begin
				$display("%0t: overflow expected %0b got %0b", $time, e.overflow, overflow);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rpi_pix_if pix_bus ();
	rpi_cfg_if cfg_bus ();
	rpi_res_if res_bus ();

	rgba_palette_indexer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_bus),
		.cfg    (cfg_bus),
		.res    (res_bus)
	);

	palette_scoreboard scoreboard;
	int                send_burst;
	bit                stall_request;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("tb: failure");
		$finish;
	end

	function automatic int sender_gap();
		int r;
		if (send_burst > 0) begin
			send_burst--;
			return 0;
		end
		r = $urandom_range(99, 0);
		if (r < 10) begin
			send_burst = $urandom_range(80, 10);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic pixel_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
		logic [7:0] a, logic first);
		pixel_t p;
		p.red = r;
		p.green = g;
		p.blue = b;
		p.alpha = a;
		p.first = first;
		return p;
	endfunction

	function automatic logic [CHAN_W-1:0] raw_channel(logic [QCH_W-1:0] q);
		int lo;
		int hi;
		lo = 17 * int'(q) - 8;
		hi = 17 * int'(q) + 8;
		if (lo < 0)
			lo = 0;
		if (hi > 255)
			hi = 255;
		return CHAN_W'($urandom_range(hi, lo));
	endfunction

	function automatic pixel_t shade_pixel(logic [COLOR_W-1:0] color, logic first);
		logic [CHAN_W-1:0] a;
		if ($urandom_range(99, 0) < 85)
			a = CHAN_W'($urandom_range(255, int'(scoreboard.threshold)));
		else
			a = CHAN_W'($urandom_range(255, 0));
		return make_pixel(raw_channel(color[11:8]), raw_channel(color[7:4]),
			raw_channel(color[3:0]), a, first);
	endfunction

	function automatic pixel_t noise_pixel();
		return make_pixel(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
			8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
			$urandom_range(15, 0) == 0);
	endfunction

	task automatic send_pixel(input pixel_t p);
		int gap;
		bit taken;
		gap = sender_gap();
		if (gap > 0) begin
			pix_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_bus.valid       <= 1'b1;
		pix_bus.red         <= p.red;
		pix_bus.green       <= p.green;
		pix_bus.blue        <= p.blue;
		pix_bus.alpha       <= p.alpha;
		pix_bus.first_pixel <= p.first;
		forever begin
			@(negedge clk);
			taken = pix_bus.ready;
			@(posedge clk);
			if (taken)
				break;
		end
		scoreboard.note_pixel(p);
	endtask

	task automatic send_image(input int count);
		logic [COLOR_W-1:0] shades [$];
		int                 k;
		k = ($urandom_range(9, 0) < 7) ? $urandom_range(12, 1) : $urandom_range(20, 13);
		repeat (k) shades = {shades, COLOR_W'($urandom_range(4095, 0))};
		for (int i = 0; i < count; i++)
			send_pixel(shade_pixel(shades[$urandom_range(k - 1, 0)], i == 0));
	endtask

	task automatic wait_for_results();
		pix_bus.valid <= 1'b0;
		while (scoreboard.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [CHAN_W-1:0] value);
		bit taken;
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= value;
		forever begin
			@(negedge clk);
			taken = cfg_bus.ready;
			@(posedge clk);
			if (taken)
				break;
		end
		cfg_bus.valid <= 1'b0;
		scoreboard.set_threshold(value);
	endtask

	initial begin : result_sink
		logic [IDX_W-1:0]   got_index;
		logic               got_fresh;
		logic [COLOR_W-1:0] got_color;
		logic               got_overflow;
		bit                 fire;
		int                 hold_cycles;
		int                 open_cycles;
		int                 r;
		hold_cycles = 0;
		open_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			fire = res_bus.valid && res_bus.ready;
			got_index = res_bus.color_index;
			got_fresh = res_bus.new_entry;
			got_color = res_bus.entry_color;
			got_overflow = res_bus.overflow;
			@(posedge clk);
			if (fire)
				scoreboard.check_result(got_index, got_fresh, got_color, got_overflow);
			if (stall_request) begin
				stall_request = 1'b0;
				hold_cycles = 300;
				open_cycles = 0;
			end
			if (hold_cycles == 0 && open_cycles == 0) begin
				r = $urandom_range(99, 0);
				if (r < 40)
					open_cycles = $urandom_range(60, 5);
				else if (r < 85)
					hold_cycles = $urandom_range(3, 1);
				else
					hold_cycles = $urandom_range(40, 10);
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				res_bus.ready <= 1'b0;
			end else begin
				open_cycles--;
				res_bus.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [CHAN_W-1:0] phase_thresholds [6];
		int                left;
		int                n;
		scoreboard = new();
		send_burst = 0;
		stall_request = 1'b0;
		arst_n = 1'b0;
		pix_bus.valid = 1'b0;
		pix_bus.red = '0;
		pix_bus.green = '0;
		pix_bus.blue = '0;
		pix_bus.alpha = '0;
		pix_bus.first_pixel = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = '0;
		res_bus.ready = 1'b0;
		phase_thresholds = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd128, 8'd0};
		phase_thresholds[3] = 8'($urandom_range(254, 2));
		phase_thresholds[5] = 8'($urandom_range(254, 2));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners under the reset threshold
		send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1));
		send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
		send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd127, 1'b0));
		send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd128, 1'b0));
		send_pixel(make_pixel(8'd8, 8'd8, 8'd8, 8'd200, 1'b0));
		send_pixel(make_pixel(8'd9, 8'd9, 8'd9, 8'd200, 1'b0));
		for (int q = 2; q <= 13; q++)
			send_pixel(make_pixel(8'(17 * q), 8'(17 * q), 8'(17 * q), 8'd255, 1'b0));
		send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b0));
		send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b0));
		send_pixel(make_pixel(8'd10, 8'd20, 8'd30, 8'd5, 1'b0));
		send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 8'd0, 1'b1));
		send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 8'd255, 1'b0));

		for (int ph = 0; ph < 6; ph++) begin
			wait_for_results();
			write_threshold(phase_thresholds[ph]);
			if (ph == 3)
				stall_request = 1'b1;
			left = 255;
			while (left > 0) begin
				if ($urandom_range(9, 0) == 0) begin
					n = $urandom_range(5, 1);
					if (n > left)
						n = left;
					repeat (n) send_pixel(noise_pixel());
				end else begin
					n = $urandom_range(60, 4);
					if (n > left)
						n = left;
					send_image(n);
				end
				left -= n;
			end
		end
		wait_for_results();
		repeat (20) @(posedge clk);
		if (scoreboard.errors == 0 && scoreboard.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
